/* src/prfc_pkg.sv */
// Shared types and constants for the physical register file with checkpoints.
// Holds the beat field widths, the operation and state encodings and the lane control struct.
// No dependencies; every other file in src imports this package.
package prfc_pkg;

    localparam int FUNC_W  = 2;
    localparam int TAG_W   = 4;
    localparam int REG_W   = 6;
    localparam int VALUE_W = 32;
    localparam int MASK_W  = 64;

    // Operation selected by one input beat. The fourth code is a hold cycle.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_NORMAL  = 2'd0,
        FUNC_FLUSH   = 2'd1,
        FUNC_RECOVER = 2'd2
    } t_func;

    typedef enum logic {
        ST_IDLE,
        ST_RESTORE
    } t_state;

    // Writeback and allocation fields of one beat, broadcast to every lane.
    typedef struct packed {
        logic [REG_W-1:0]   alloc_reg;
        logic [REG_W-1:0]   alu_reg;
        logic [VALUE_W-1:0] alu_value;
        logic [REG_W-1:0]   lsu_reg;
        logic [VALUE_W-1:0] lsu_value;
        logic [REG_W-1:0]   bru_reg;
        logic [VALUE_W-1:0] bru_value;
    } t_wb_set;

    // Per-cycle control from the sequencer to all lanes.
    typedef struct packed {
        logic normal;      // normal cycle accepted: apply writebacks and allocation
        logic take;        // store the post-write state into the addressed slot
        logic rd_en;       // read the addressed slot for a restore next cycle
        logic restore;     // load the slot data read in the previous cycle
        logic snap_valid;  // the slot being restored was written since reset
    } t_lane_ctrl;

endpackage

/* src/prfc_in_if.sv */
// Input channel of the checkpointed register file: valid, ready and one beat of fields.
// Depends on prfc_pkg for the field widths.
interface prfc_in_if import prfc_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [TAG_W-1:0]   rob_tag;
    logic               take_snapshot;
    logic [REG_W-1:0]   alloc_reg;
    logic [REG_W-1:0]   alu_reg;
    logic [VALUE_W-1:0] alu_value;
    logic [REG_W-1:0]   lsu_reg;
    logic [VALUE_W-1:0] lsu_value;
    logic [REG_W-1:0]   bru_reg;
    logic [VALUE_W-1:0] bru_value;

    modport source (
        output valid, func, rob_tag, take_snapshot, alloc_reg,
               alu_reg, alu_value, lsu_reg, lsu_value, bru_reg, bru_value,
        input  ready
    );

    modport sink (
        input  valid, func, rob_tag, take_snapshot, alloc_reg,
               alu_reg, alu_value, lsu_reg, lsu_value, bru_reg, bru_value,
        output ready
    );

endinterface

/* src/prfc_out_if.sv */
// Output channel of the checkpointed register file: valid, ready and the ready mask.
// Depends on prfc_pkg for the mask width.
interface prfc_out_if import prfc_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] ready_mask;

    modport source (
        output valid, ready_mask,
        input  ready
    );

    modport sink (
        input  valid, ready_mask,
        output ready
    );

endinterface

/* src/prfc_lane.sv */
// One physical register lane: its value, its ready bit and its snapshot memory.
// Depends on prfc_pkg for t_lane_ctrl and t_wb_set.
module prfc_lane import prfc_pkg::*; #(
    parameter int LANE_ID    = 1,
    parameter int DATA_WIDTH = 32,
    parameter int SNAP_SLOTS = 16,
    parameter int SLOT_W     = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_lane_ctrl        i_ctrl,
    input  logic [SLOT_W-1:0] i_slot,
    input  t_wb_set           i_wb,
    output logic              o_n_ready
);

    localparam logic [REG_W-1:0] LANE_REG = REG_W'(LANE_ID);

    logic                  hit_alu;
    logic                  hit_lsu;
    logic                  hit_bru;
    logic                  hit_alloc;
    logic [DATA_WIDTH-1:0] r_value;
    logic [DATA_WIDTH-1:0] n_value;
    logic                  r_ready;
    logic                  n_ready;
    // Each snapshot word holds the ready bit above the data.
    logic [DATA_WIDTH:0]   r_mem [SNAP_SLOTS];
    logic [DATA_WIDTH:0]   r_rd_data;

    assign hit_alu   = (i_wb.alu_reg == LANE_REG);
    assign hit_lsu   = (i_wb.lsu_reg == LANE_REG);
    assign hit_bru   = (i_wb.bru_reg == LANE_REG);
    assign hit_alloc = (i_wb.alloc_reg == LANE_REG);

    always_comb begin
        n_value = r_value;
        n_ready = r_ready;
        if (i_ctrl.restore) begin
            // A slot never written reads as a zero register that is ready.
            n_value = i_ctrl.snap_valid ? r_rd_data[DATA_WIDTH-1:0] : '0;
            n_ready = i_ctrl.snap_valid ? r_rd_data[DATA_WIDTH] : 1'b1;
        end else if (i_ctrl.normal) begin
            // The branch port is the last writer and wins over the other two.
            priority if (hit_bru) begin
                n_value = DATA_WIDTH'(i_wb.bru_value);
            end else if (hit_lsu) begin
                n_value = DATA_WIDTH'(i_wb.lsu_value);
            end else if (hit_alu) begin
                n_value = DATA_WIDTH'(i_wb.alu_value);
            end else begin
                n_value = r_value;
            end
            priority if (hit_alu || hit_lsu || hit_bru) begin
                n_ready = 1'b1;
            end else if (hit_alloc) begin
                n_ready = 1'b0;
            end else begin
                n_ready = r_ready;
            end
        end
    end

    assign o_n_ready = n_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
            r_ready <= 1'b1;
        end else begin
            r_value <= n_value;
            r_ready <= n_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.take) begin
            r_mem[i_slot] <= {n_ready, n_value};
        end
        if (i_ctrl.rd_en) begin
            r_rd_data <= r_mem[i_slot];
        end
    end

endmodule

/* src/prfc_merge.sv */
// Merge stage: gathers the lane ready bits into the ready mask and holds the output beat.
// Depends on prfc_pkg for MASK_W and on prfc_out_if for the output channel.
module prfc_merge import prfc_pkg::*; #(
    parameter int PHYS_REGS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic [PHYS_REGS-1:1] i_lane_ready,
    prfc_out_if.source           o_out
);

    logic [MASK_W-1:0] n_mask;
    logic [MASK_W-1:0] r_mask;
    logic              r_out_valid;

    // Register 0 is always ready; bits above the register count stay zero.
    assign n_mask = MASK_W'({i_lane_ready, 1'b1});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mask <= n_mask;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.ready_mask = r_mask;

endmodule

/* src/physical_register_file_checkpoint.sv */
// Physical register file with ready bits and per-tag checkpoints, one lane per register above 0.
// The ready mask beat is registered when a normal, flush or hold beat is accepted; a recover beat
// from an existing slot registers its snapshot memory read in every lane and loads it in restore.
// Throughput: one beat per cycle while the output drains; a recover from a slot adds the restore state.
// Reset: registers read zero and are all ready, every snapshot slot is marked empty and
// reads as zero and all ready; no clearing pass, the block accepts beats right after reset.
module physical_register_file_checkpoint import prfc_pkg::*; #(
    parameter int PHYS_REGS  = 64,
    parameter int SNAP_SLOTS = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    prfc_in_if.sink    i_in,
    prfc_out_if.source o_out
);

    localparam int SLOT_W = (SNAP_SLOTS > 1) ? $clog2(SNAP_SLOTS) : 1;

    // Sequencer state. A recover passes through a restore state because the lanes keep their
    // snapshots in memories with a registered read port.
    t_state                r_state;
    t_state                n_state;
    logic                  in_ready;
    logic                  accept;
    logic                  is_normal;
    logic                  is_recover;
    logic                  slot_ok;
    logic [SLOT_W-1:0]     in_slot;
    logic                  load;
    t_lane_ctrl            lane_ctrl;
    t_wb_set               wb_set;
    logic [PHYS_REGS-1:1]  lane_ready;
    // One flag per slot marks a slot written since reset; empty slots restore reset state.
    logic [SNAP_SLOTS-1:0] r_slot_valid;
    logic                  r_snap_hit;

    // Decode the operation. Flush and the unused code change nothing, because
    // register 0 is built as a constant zero that is always ready.
    always_comb begin
        is_normal  = 1'b0;
        is_recover = 1'b0;
        unique case (i_in.func)
            FUNC_NORMAL:  is_normal  = 1'b1;
            FUNC_FLUSH:   is_normal  = 1'b0;
            FUNC_RECOVER: is_recover = 1'b1;
            default:      is_normal  = 1'b0;
        endcase
    end

    // Tags beyond the slot count make a take or a recover a no-op.
    assign slot_ok = (int'(i_in.rob_tag) < SNAP_SLOTS);
    assign in_slot = SLOT_W'(i_in.rob_tag);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && is_recover && slot_ok) begin
                    n_state = ST_RESTORE;
                end
            end
            ST_RESTORE: n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // A new beat enters only when the output register is empty or being drained,
    // so the restore cycle can always load its mask.
    always_comb begin
        in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE:    in_ready = !o_out.valid || o_out.ready;
            ST_RESTORE: in_ready = 1'b0;
            default:    in_ready = 1'b0;
        endcase
    end

    assign i_in.ready = in_ready;
    assign accept     = i_in.valid && in_ready;

    always_comb begin
        lane_ctrl.normal     = accept && is_normal;
        lane_ctrl.take       = accept && is_normal && i_in.take_snapshot && slot_ok;
        lane_ctrl.rd_en      = accept && is_recover && slot_ok;
        lane_ctrl.restore    = (r_state == ST_RESTORE);
        lane_ctrl.snap_valid = r_snap_hit;
    end

    // Every beat but a recover that reads a slot finishes in the cycle it is accepted.
    assign load = lane_ctrl.restore || (accept && !lane_ctrl.rd_en);

    always_comb begin
        wb_set.alloc_reg = i_in.alloc_reg;
        wb_set.alu_reg   = i_in.alu_reg;
        wb_set.alu_value = i_in.alu_value;
        wb_set.lsu_reg   = i_in.lsu_reg;
        wb_set.lsu_value = i_in.lsu_value;
        wb_set.bru_reg   = i_in.bru_reg;
        wb_set.bru_value = i_in.bru_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_slot_valid <= '0;
            r_snap_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (lane_ctrl.take) begin
                r_slot_valid[in_slot] <= 1'b1;
            end
            if (lane_ctrl.rd_en) begin
                r_snap_hit <= r_slot_valid[in_slot];
            end
        end
    end

    // Lanes for registers 1 and up work side by side on the same beat.
    for (genvar g = 1; g < PHYS_REGS; g++) begin : g_lane
        prfc_lane #(
            .LANE_ID    (g),
            .DATA_WIDTH (DATA_WIDTH),
            .SNAP_SLOTS (SNAP_SLOTS),
            .SLOT_W     (SLOT_W)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (lane_ctrl),
            .i_slot    (in_slot),
            .i_wb      (wb_set),
            .o_n_ready (lane_ready[g])
        );
    end

    prfc_merge #(
        .PHYS_REGS (PHYS_REGS)
    ) u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_lane_ready (lane_ready),
        .o_out        (o_out)
    );

    // Register 0 is reported ready in every output beat.
    a_zero_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.ready_mask[0])
        else $error("register 0 not ready in output beat");

    // No ready bit appears for registers that do not exist.
    a_mask_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.ready_mask >> PHYS_REGS) == '0))
        else $error("ready bit set beyond the register count");

    // A recover from an existing slot goes through the restore cycle.
    a_recover_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lane_ctrl.rd_en |=> (r_state == ST_RESTORE))
        else $error("recover did not enter the restore cycle");

    // The restore cycle always delivers its beat into the output register.
    a_restore_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESTORE) |=> o_out.valid)
        else $error("restore cycle produced no output beat");

    // No beat is accepted while a restore is in flight.
    a_restore_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESTORE) |-> !accept)
        else $error("beat accepted during restore");

endmodule
